>>> sv/pq_nearest_center_search_core_assert.svh
// Assertion macros for the nearest center search core.
// Included by the checker file; needs nothing else.
`ifndef PQ_NEAREST_CENTER_SEARCH_CORE_ASSERT_SVH
`define PQ_NEAREST_CENTER_SEARCH_CORE_ASSERT_SVH

// same-cycle implication
`define PQNS_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PQNS_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pqns_pkg.sv
// Shared types and constants for the nearest center search core.
// No dependencies; every file but pqns_ram and the assertion header imports it.
package pqns_pkg;

  localparam int MAX_SUBSPACES_DEF = 8;
  localparam int CODEWORDS_DEF     = 256;
  localparam int MAX_CENTERS_DEF   = 256;
  localparam int DIST_BITS_DEF     = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam int SUM_BITS        = 36;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 9;
  localparam int CFG_CENTERS_W   = 9;
  localparam int CFG_SUBSPACES_W = 4;

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  // operation codes of an input item
  localparam logic [1:0] OP_LOAD_DIST   = 2'd0;
  localparam logic [1:0] OP_LOAD_CENTER = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTERS_IN_USE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUBSPACES_IN_USE = 2'd1;

  typedef enum logic [1:0] {
    CMD_TABLE,
    CMD_CENTER,
    CMD_QUERY,
    CMD_SEARCH
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  subspace;
    logic [7:0]  first_code;
    logic [7:0]  second_code;
    logic [7:0]  center_number;
    logic [31:0] table_distance;
    logic        last_subcode;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          nearest_center;
    logic [SUM_BITS-1:0] nearest_distance;
  } result_t;

  // classified command passed from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  subspace;
    logic [7:0]  code_row;
    logic [7:0]  code_col;
    logic [7:0]  center;
    logic [31:0] distance;
  } qentry_t;

endpackage

>>> sv/pqns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pqns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pqns_front.sv
// Front end: accepts input items, drops unusable ones, saturates codes
// and registers a classified command. Depends on pqns_pkg.
module pqns_front #(
  parameter int MAX_SUBSPACES = pqns_pkg::MAX_SUBSPACES_DEF,
  parameter int CODEWORDS     = pqns_pkg::CODEWORDS_DEF,
  parameter int MAX_CENTERS   = pqns_pkg::MAX_CENTERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  pqns_pkg::in_item_t item,
  output logic               fq_valid,
  input  logic               fq_ready,
  output pqns_pkg::qentry_t  fq_entry
);
  import pqns_pkg::*;

  logic    sub_ok, row_ok, col_ok, ctr_ok, keep;
  qentry_t entry_next;

  always_comb begin
    sub_ok = 32'(item.subspace) < MAX_SUBSPACES;
    row_ok = 32'(item.first_code) < CODEWORDS;
    col_ok = 32'(item.second_code) < CODEWORDS;
    ctr_ok = 32'(item.center_number) < MAX_CENTERS;

    entry_next.subspace = item.subspace;
    entry_next.code_row = row_ok ? item.first_code : 8'(CODEWORDS - 1);
    entry_next.code_col = col_ok ? item.second_code : 8'(CODEWORDS - 1);
    entry_next.center   = item.center_number;
    entry_next.distance = item.table_distance;
    entry_next.kind     = CMD_QUERY;
    keep                = 1'b0;

    case (item.op)
      OP_LOAD_DIST: begin
        entry_next.kind = CMD_TABLE;
        keep            = sub_ok && row_ok && col_ok;
      end
      OP_LOAD_CENTER: begin
        entry_next.kind = CMD_CENTER;
        keep            = sub_ok && ctr_ok;
      end
      OP_QUERY: begin
        entry_next.kind = item.last_subcode ? CMD_SEARCH : CMD_QUERY;
        keep            = sub_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item_ready = !fq_valid || fq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fq_valid <= 1'b0;
    end else if (item_ready) begin
      fq_valid <= item_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      fq_entry <= entry_next;
    end
  end

endmodule

>>> sv/pqns_queue.sv
// Short command queue between front and back end.
// Depends on pqns_pkg.
module pqns_queue #(
  parameter int DEPTH = pqns_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  pqns_pkg::qentry_t wr_entry,
  output logic              rd_valid,
  input  logic              rd_ready,
  output pqns_pkg::qentry_t rd_entry
);
  import pqns_pkg::*;

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qentry_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

>>> sv/pqns_back.sv
// Back end: executes table, center and query writes, runs the search
// sequencer over the two RAMs and holds the result register. Depends on
// pqns_pkg and pqns_ram.
module pqns_back #(
  parameter int MAX_SUBSPACES = pqns_pkg::MAX_SUBSPACES_DEF,
  parameter int CODEWORDS     = pqns_pkg::CODEWORDS_DEF,
  parameter int MAX_CENTERS   = pqns_pkg::MAX_CENTERS_DEF,
  parameter int DIST_BITS     = pqns_pkg::DIST_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  pqns_pkg::qentry_t                   q_entry,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pqns_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pqns_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                result_valid,
  input  logic                                result_ready,
  output pqns_pkg::result_t                   result
);
  import pqns_pkg::*;

  localparam int SUB_W     = MAX_SUBSPACES > 1 ? $clog2(MAX_SUBSPACES) : 1;
  localparam int CIDX_W    = MAX_CENTERS > 1 ? $clog2(MAX_CENTERS) : 1;
  localparam int TBL_DEPTH = MAX_SUBSPACES * CODEWORDS * CODEWORDS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CS_DEPTH  = MAX_CENTERS * MAX_SUBSPACES;
  localparam int CS_AW     = CS_DEPTH > 1 ? $clog2(CS_DEPTH) : 1;
  localparam int ADD_W     = (DIST_BITS > SUM_BITS ? DIST_BITS : SUM_BITS) + 1;
  localparam int NC_W      = (CIDX_W + 1 > CFG_CENTERS_W) ? CIDX_W + 1 : CFG_CENTERS_W;
  localparam int NM_W      = (SUB_W + 1 > CFG_SUBSPACES_W) ? SUB_W + 1 : CFG_SUBSPACES_W;

  back_state_t state, state_next;

  logic [CFG_CENTERS_W-1:0]   centers_in_use;
  logic [CFG_SUBSPACES_W-1:0] subspaces_in_use;
  logic [7:0]                 query_code [MAX_SUBSPACES];

  logic [CIDX_W-1:0] nc_last, c_cnt;
  logic [SUB_W-1:0]  nm_last, m_cnt;
  logic [NC_W-1:0]   nc_ext, nc_clamp;
  logic [NM_W-1:0]   nm_ext, nm_clamp;

  logic              p1_valid, p1_first, p1_mlast, p1_end;
  logic [CIDX_W-1:0] p1_c;
  logic [TBL_AW-1:0] p1_row;
  logic              p2_valid, p2_first, p2_mlast, p2_end;
  logic [CIDX_W-1:0] p2_c;

  logic [SUM_BITS-1:0] acc, best_sum, sum_sat, base;
  logic [CIDX_W-1:0]   best_index;
  logic [ADD_W-1:0]    total, dist_wide;

  logic pop, start, issue, issue_end, load_result;

  logic                 tbl_we, cs_we;
  logic [TBL_AW-1:0]    tbl_waddr, tbl_raddr, row0;
  logic [DIST_BITS-1:0] tbl_wdata, tbl_rdata;
  logic [CS_AW-1:0]     cs_waddr, cs_raddr;
  logic [7:0]           cs_rdata, q_sel;

  assign cfg_ready = 1'b1;

  // control
  assign issue       = state == BK_ISSUE;
  assign issue_end   = issue && (m_cnt == nm_last) && (c_cnt == nc_last);
  assign load_result = (state == BK_DONE) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    case (state)
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && q_entry.kind == CMD_SEARCH) begin
          state_next = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        if (issue_end) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (p2_valid && p2_end) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (load_result) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign pop   = q_valid && q_ready;
  assign start = pop && q_entry.kind == CMD_SEARCH;

  // register limits clamped to the store sizes
  always_comb begin
    nc_ext   = NC_W'(centers_in_use);
    nc_clamp = (nc_ext == '0) ? NC_W'(1) :
               (nc_ext > NC_W'(MAX_CENTERS)) ? NC_W'(MAX_CENTERS) : nc_ext;
    nm_ext   = NM_W'(subspaces_in_use);
    nm_clamp = (nm_ext == '0) ? NM_W'(1) :
               (nm_ext > NM_W'(MAX_SUBSPACES)) ? NM_W'(MAX_SUBSPACES) : nm_ext;
  end

  // write side
  assign tbl_we    = pop && q_entry.kind == CMD_TABLE;
  assign tbl_waddr = (TBL_AW'(q_entry.subspace) * TBL_AW'(CODEWORDS)
                      + TBL_AW'(q_entry.code_row)) * TBL_AW'(CODEWORDS)
                     + TBL_AW'(q_entry.code_col);
  assign dist_wide = ADD_W'(q_entry.distance);
  assign tbl_wdata = dist_wide[DIST_BITS-1:0];

  assign cs_we    = pop && q_entry.kind == CMD_CENTER;
  assign cs_waddr = CS_AW'(q_entry.center) * CS_AW'(MAX_SUBSPACES)
                    + CS_AW'(q_entry.subspace);

  // stage 0: centre subcode read, table row offset
  assign q_sel    = query_code[m_cnt];
  assign cs_raddr = CS_AW'(c_cnt) * CS_AW'(MAX_SUBSPACES) + CS_AW'(m_cnt);
  assign row0     = (TBL_AW'(m_cnt) * TBL_AW'(CODEWORDS) + TBL_AW'(q_sel))
                    * TBL_AW'(CODEWORDS);

  // stage 1: table read
  assign tbl_raddr = p1_row + TBL_AW'(cs_rdata);

  // stage 2: saturating accumulate
  always_comb begin
    base    = p2_first ? '0 : acc;
    total   = ADD_W'(base) + ADD_W'(tbl_rdata);
    sum_sat = (total > ADD_W'(SUM_MAX)) ? SUM_MAX : total[SUM_BITS-1:0];
  end

  pqns_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  pqns_ram #(
    .WIDTH (8),
    .DEPTH (CS_DEPTH)
  ) u_centers (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (q_entry.code_col),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      centers_in_use   <= CFG_CENTERS_W'(1);
      subspaces_in_use <= CFG_SUBSPACES_W'(8);
      for (int i = 0; i < MAX_SUBSPACES; i++) begin
        query_code[i] <= '0;
      end
      best_sum     <= SUM_MAX;
      best_index   <= '0;
      c_cnt        <= '0;
      m_cnt        <= '0;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CENTERS_IN_USE:   centers_in_use   <= cfg_data[CFG_CENTERS_W-1:0];
          CFG_SUBSPACES_IN_USE: subspaces_in_use <= cfg_data[CFG_SUBSPACES_W-1:0];
          default: ;
        endcase
      end

      if (pop && (q_entry.kind == CMD_QUERY || q_entry.kind == CMD_SEARCH)) begin
        query_code[SUB_W'(q_entry.subspace)] <= q_entry.code_row;
      end

      if (start) begin
        nc_last    <= CIDX_W'(nc_clamp - NC_W'(1));
        nm_last    <= SUB_W'(nm_clamp - NM_W'(1));
        c_cnt      <= '0;
        m_cnt      <= '0;
        best_sum   <= SUM_MAX;
        best_index <= '0;
      end

      p1_valid <= issue;
      if (issue) begin
        p1_first <= m_cnt == '0;
        p1_mlast <= m_cnt == nm_last;
        p1_end   <= issue_end;
        p1_c     <= c_cnt;
        p1_row   <= row0;
        if (m_cnt == nm_last) begin
          m_cnt <= '0;
          c_cnt <= c_cnt + 1'b1;
        end else begin
          m_cnt <= m_cnt + 1'b1;
        end
      end

      p2_valid <= p1_valid;
      p2_first <= p1_first;
      p2_mlast <= p1_mlast;
      p2_end   <= p1_end;
      p2_c     <= p1_c;

      if (p2_valid) begin
        acc <= sum_sat;
        // strict compare keeps the first centre on ties
        if (p2_mlast && sum_sat < best_sum) begin
          best_sum   <= sum_sat;
          best_index <= p2_c;
        end
      end

      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.nearest_center   <= 8'(best_index);
      result.nearest_distance <= best_sum;
    end
  end

endmodule

>>> sv/pq_nearest_center_search_core.sv
// Channel   Handshake                 Payload
// item      item_valid / item_ready   item   (pqns_pkg::in_item_t)
// cfg       cfg_valid  / cfg_ready    cfg_index, cfg_data
// result    result_valid / result_ready  result (pqns_pkg::result_t)
//
// Load and query items: one transfer per cycle through front, queue and back while the back end is idle.
// Search: one table RAM read per cycle for each centre and subspace in use (up to
// 256 x 8 = 2048 reads), then the drain of stages 1 and 2 and the result register.
// Reset: synchronous; tables and centre store are not cleared, no sweep.
// A waiting result holds the next finished search and the items queued behind it.
// Top level of the nearest center search core. Depends on pqns_pkg,
// pqns_front, pqns_queue and pqns_back.
module pq_nearest_center_search_core #(
  parameter int MAX_SUBSPACES = pqns_pkg::MAX_SUBSPACES_DEF,
  parameter int CODEWORDS     = pqns_pkg::CODEWORDS_DEF,
  parameter int MAX_CENTERS   = pqns_pkg::MAX_CENTERS_DEF,
  parameter int DIST_BITS     = pqns_pkg::DIST_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  pqns_pkg::in_item_t               item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pqns_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pqns_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             result_valid,
  input  logic                             result_ready,
  output pqns_pkg::result_t                result
);
  import pqns_pkg::*;

  logic    fq_valid, fq_ready, bq_valid, bq_ready;
  qentry_t fq_entry, bq_entry;

  pqns_front #(
    .MAX_SUBSPACES (MAX_SUBSPACES),
    .CODEWORDS     (CODEWORDS),
    .MAX_CENTERS   (MAX_CENTERS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .fq_valid   (fq_valid),
    .fq_ready   (fq_ready),
    .fq_entry   (fq_entry)
  );

  pqns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_entry (fq_entry),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_entry (bq_entry)
  );

  pqns_back #(
    .MAX_SUBSPACES (MAX_SUBSPACES),
    .CODEWORDS     (CODEWORDS),
    .MAX_CENTERS   (MAX_CENTERS),
    .DIST_BITS     (DIST_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (bq_valid),
    .q_ready      (bq_ready),
    .q_entry      (bq_entry),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

>>> sv/pqns_checker.sv
// Port-level checks on the result channel of the search core, with bind.
// Depends on pqns_pkg and pq_nearest_center_search_core_assert.svh.
`include "pq_nearest_center_search_core_assert.svh"

module pqns_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input pqns_pkg::result_t result
);
  import pqns_pkg::*;

  `PQNS_ASSERT_NXT(a_result_held, clk, rst, result_valid && !result_ready, result_valid, "result dropped before transfer")
  `PQNS_ASSERT_NXT(a_result_stable, clk, rst, result_valid && !result_ready, $stable(result), "result changed while stalled")
  `PQNS_ASSERT_NXT(a_reset_clears, clk, 1'b0, rst, !result_valid, "result valid straight after reset")
  `PQNS_ASSERT_IMP(a_saturated_first, clk, rst, result_valid && result.nearest_distance == SUM_MAX, result.nearest_center == '0, "saturated sum not on centre zero")

endmodule

bind pq_nearest_center_search_core pqns_checker u_checker (.*);

>>> dv/pq_nearest_center_search_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pq_nearest_center_search_core: tables, centres and queries go in,
// each search result is checked against a local prediction of the nearest centre.
// Depends on pqns_pkg and the core RTL only.
module tb;
  import pqns_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid;
  logic item_ready;
  in_item_t item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic result_valid;
  logic result_ready;
  result_t result;

  // predicted block state
  logic [31:0] dist_table [int unsigned];
  logic [7:0] center_code [256][8];
  bit center_known [256][8];
  logic [7:0] query_code [8];
  logic [8:0] centers_reg;
  logic [3:0] subspaces_reg;

  result_t nearest_q [$];
  result_t want_result;
  int error_count = 0;
  int load_count = 0;
  int search_count = 0;
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  pq_nearest_center_search_core DUT (
    .clk, .rst, .item_valid, .item_ready, .item, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .result_valid, .result_ready, .result
  );

  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("FAIL pq_nearest_center_search_core");
    $finish;
  end

  function automatic int unsigned table_key(input int m, input logic [7:0] row,
                                            input logic [7:0] col);
    return (m * 256 + row) * 256 + col;
  endfunction

  function automatic int active_centers();
    if (centers_reg == 0) return 1;
    if (centers_reg > 256) return 256;
    return centers_reg;
  endfunction

  function automatic int active_subspaces();
    if (subspaces_reg == 0) return 1;
    if (subspaces_reg > 8) return 8;
    return subspaces_reg;
  endfunction

  // mostly a small pool of codes so table entries get reused
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1: return 8'd0;
      2, 3: return 8'd1;
      4, 5: return 8'd254;
      6, 7: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_dist();
    case ($urandom_range(0, 9))
      0, 1: return 32'd0;
      2: return 32'hFFFF_FFFF;
      3, 4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // unused fields stay random
  function automatic in_item_t rand_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  // offer one item, update the prediction on its transfer
  task automatic send_item(input in_item_t it);
    int nc;
    int nm;
    logic [36:0] acc;
    result_t best;
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_ready !== 1'b1) @(posedge clk);
    case (it.op)
      OP_LOAD_DIST: begin
        dist_table[table_key(it.subspace, it.first_code, it.second_code)] = it.table_distance;
        load_count++;
      end
      OP_LOAD_CENTER: begin
        center_code[it.center_number][it.subspace] = it.second_code;
        center_known[it.center_number][it.subspace] = 1'b1;
        load_count++;
      end
      OP_QUERY: begin
        query_code[it.subspace] = it.first_code;
        load_count++;
        if (it.last_subcode) begin
          nc = active_centers();
          nm = active_subspaces();
          best.nearest_center = '0;
          best.nearest_distance = SUM_MAX;
          for (int c = 0; c < nc; c++) begin
            acc = '0;
            for (int m = 0; m < nm; m++) begin
              acc = acc + dist_table[table_key(m, query_code[m], center_code[c][m])];
              if (acc > SUM_MAX) acc = 37'(SUM_MAX);
            end
            if (acc < best.nearest_distance) begin
              best.nearest_distance = acc[SUM_BITS-1:0];
              best.nearest_center = c[7:0];
            end
          end
          nearest_q.push_back(best);
          search_count++;
        end
      end
      default: ;
    endcase
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // drain results, then let trailing loads clear the pipeline
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(input int centers, input int subspaces, input bit with_spare);
    logic [CFG_INDEX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    int n;
    wait_idle();
    idx[0] = CFG_CENTERS_IN_USE;
    val[0] = centers[8:0];
    idx[1] = CFG_SUBSPACES_IN_USE;
    val[1] = subspaces[8:0];
    n = 2;
    if (with_spare) begin
      idx[2] = $urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
      val[2] = 9'($urandom_range(0, 511));
      n = 3;
    end
    for (int i = 0; i < n; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      case (idx[i])
        CFG_CENTERS_IN_USE: centers_reg = val[i];
        CFG_SUBSPACES_IN_USE: subspaces_reg = val[i][3:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // write whatever the search will read that is still unwritten, then the last subcode
  task automatic run_search(input logic [2:0] m_last, input logic [7:0] q_last);
    int nc;
    int nm;
    logic [7:0] row;
    in_item_t it;
    nc = active_centers();
    nm = active_subspaces();
    for (int c = 0; c < nc; c++) begin
      for (int m = 0; m < nm; m++) begin
        if (!center_known[c][m]) begin
          it = rand_item();
          it.op = OP_LOAD_CENTER;
          it.subspace = m[2:0];
          it.center_number = c[7:0];
          it.second_code = pick_code();
          send_item(it);
        end
        row = (m == m_last) ? q_last : query_code[m];
        if (!dist_table.exists(table_key(m, row, center_code[c][m]))) begin
          it = rand_item();
          it.op = OP_LOAD_DIST;
          it.subspace = m[2:0];
          it.first_code = row;
          it.second_code = center_code[c][m];
          it.table_distance = pick_dist();
          send_item(it);
        end
      end
    end
    it = rand_item();
    it.op = OP_QUERY;
    it.subspace = m_last;
    it.first_code = q_last;
    it.last_subcode = 1'b1;
    send_item(it);
  endtask

  task automatic send_noise();
    in_item_t it;
    it = rand_item();
    case ($urandom_range(0, 3))
      0: begin
        it.op = OP_LOAD_DIST;
        it.first_code = pick_code();
        it.second_code = pick_code();
        it.table_distance = pick_dist();
      end
      1: begin
        it.op = OP_LOAD_CENTER;
        it.second_code = pick_code();
      end
      2: begin
        it.op = OP_QUERY;
        it.first_code = pick_code();
        it.last_subcode = 1'b0;
      end
      default: it.op = OP_RESERVED;
    endcase
    send_item(it);
  endtask

  // registers at reset: one centre, eight subspaces, every entry at full scale
  task automatic test_reset_defaults();
    in_item_t it;
    for (int m = 0; m < 8; m++) begin
      it = rand_item();
      it.op = OP_LOAD_CENTER;
      it.subspace = m[2:0];
      it.center_number = 8'd0;
      it.second_code = (m == 7) ? 8'd255 : ((m % 2) ? 8'd254 : 8'd0);
      send_item(it);
      it = rand_item();
      it.op = OP_LOAD_DIST;
      it.subspace = m[2:0];
      it.first_code = (m == 7) ? 8'd255 : 8'd0;
      it.second_code = center_code[0][m];
      it.table_distance = 32'hFFFF_FFFF;
      send_item(it);
    end
    run_search(3'd7, 8'd255);
  endtask

  // last mark on other ops and the reserved op must not start a search
  task automatic test_ignored_items();
    in_item_t it;
    it = rand_item();
    it.op = OP_RESERVED;
    it.last_subcode = 1'b1;
    send_item(it);
    it = rand_item();
    it.op = OP_LOAD_DIST;
    it.last_subcode = 1'b1;
    send_item(it);
    it = rand_item();
    it.op = OP_LOAD_CENTER;
    it.last_subcode = 1'b1;
    send_item(it);
    wait_idle();
  endtask

  // equal sums keep the lowest index
  task automatic test_tie_order();
    in_item_t it;
    set_config(4, 1, 1'b0);
    for (int c = 1; c < 4; c++) begin
      it = rand_item();
      it.op = OP_LOAD_CENTER;
      it.subspace = 3'd0;
      it.center_number = c[7:0];
      it.second_code = (c % 2) ? 8'd1 : 8'd0;
      send_item(it);
    end
    it = rand_item();
    it.op = OP_LOAD_DIST;
    it.subspace = 3'd0;
    it.first_code = 8'd0;
    it.second_code = 8'd1;
    it.table_distance = 32'hFFFF_FFFF;
    send_item(it);
    run_search(3'd0, 8'd0);
    it.table_distance = 32'd0;
    send_item(it);
    run_search(3'd0, 8'd0);
  endtask

  // register extremes, clamping and masking of the upper data bits
  task automatic test_config_extremes();
    set_config(511, 0, 1'b1);
    run_search(3'($urandom_range(0, 7)), pick_code());
    set_config(0, 15, 1'b1);
    run_search(3'($urandom_range(0, 7)), pick_code());
    set_config(256, 9'h1F1, 1'b0);
    run_search(3'($urandom_range(0, 7)), pick_code());
    set_config(1, 8, 1'b0);
    run_search(3'($urandom_range(0, 7)), pick_code());
  endtask

  // receiver holds off while searches queue up behind the waiting result
  task automatic test_backpressure();
    set_config(2, 2, 1'b0);
    run_search(3'd0, pick_code());
    wait_idle();
    idle_on = 1'b0;
    hold_cycles = 600;
    repeat (6) run_search(3'($urandom_range(0, 7)), pick_code());
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int base_items;
    int base_searches;
    int nc;
    int nm;
    in_item_t it;
    base_items = load_count;
    base_searches = search_count;
    while (load_count - base_items < 290 || search_count - base_searches < 40) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
          nc = $urandom_range(1, 8);
          nm = $urandom_range(1, 8);
        end
        13, 14, 15, 16: begin
          nc = $urandom_range(9, 48);
          nm = $urandom_range(1, 3);
        end
        17: begin
          nc = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
          nm = $urandom_range(0, 1);
        end
        18: begin
          nc = $urandom_range(1, 4);
          nm = $urandom_range(9, 15);
        end
        default: begin
          nc = $urandom_range(100, 256);
          nm = 1;
        end
      endcase
      set_config(nc, nm, $urandom_range(0, 3) == 0);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 5)) begin
        repeat ($urandom_range(0, 3)) send_noise();
        repeat ($urandom_range(0, 3)) begin
          it = rand_item();
          it.op = OP_QUERY;
          it.first_code = pick_code();
          it.last_subcode = 1'b0;
          send_item(it);
        end
        run_search(3'($urandom_range(0, 7)), pick_code());
      end
    end
    idle_on = 1'b1;
  endtask

  // back-to-back transfers on both sides
  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_config($urandom_range(1, 8), $urandom_range(1, 4), 1'b0);
    repeat (8) begin
      send_noise();
      run_search(3'($urandom_range(0, 7)), pick_code());
    end
  endtask

  // receiver: random stalls, plus the long hold-off when asked
  initial begin
    result_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        result_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        result_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_ready === 1'b1) begin
      if (nearest_q.size() == 0) begin
        if (error_count < 40)
          $error("result transfer with nothing pending: nearest_center %0d nearest_distance %0d",
                 result.nearest_center, result.nearest_distance);
        error_count++;
      end else begin
        want_result = nearest_q.pop_front();
        if (result.nearest_center !== want_result.nearest_center) begin
          if (error_count < 40)
            $error("nearest_center: expected %0d, actual %0d",
                   want_result.nearest_center, result.nearest_center);
          error_count++;
        end
        if (result.nearest_distance !== want_result.nearest_distance) begin
          if (error_count < 40)
            $error("nearest_distance: expected %0d, actual %0d",
                   want_result.nearest_distance, result.nearest_distance);
          error_count++;
        end
      end
    end
  end

  initial begin
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    centers_reg = 9'd1;
    subspaces_reg = 4'd8;
    for (int m = 0; m < 8; m++) query_code[m] = 8'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_ignored_items();
    test_tie_order();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();
    wait_idle();
    repeat (40) @(posedge clk);
    if (error_count == 0 && nearest_q.size() == 0) begin
      $display("PASS pq_nearest_center_search_core");
    end else begin
      $display("FAIL pq_nearest_center_search_core");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+sv
sv/pqns_pkg.sv
sv/pqns_ram.sv
sv/pqns_front.sv
sv/pqns_queue.sv
sv/pqns_back.sv
sv/pq_nearest_center_search_core.sv
sv/pqns_checker.sv
dv/pq_nearest_center_search_core_tb.sv
